@@ hdl/fcst_pkg.sv @@
// shared constants, types and ring geometry for the segment-test corner detector
`default_nettype none

package fcst_pkg;

  // image geometry
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxRows   = 4096;
  localparam int unsigned Radius    = 3;
  localparam int unsigned WinSize   = 2 * Radius + 1;
  localparam int unsigned NumLines  = 2 * Radius;
  localparam int unsigned RingLen   = 16;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxRows);
  localparam int unsigned LwW       = ColW + 1;
  localparam int unsigned LineWordW = 8 * NumLines;

  // configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [1:0] CFG_LINE_WIDTH = 2'd1;
  localparam logic [1:0] CFG_MIN_ARC    = 2'd2;

  // register reset values and clamp limits
  localparam logic [7:0]     THRESHOLD_RST  = 8'd20;
  localparam logic [LwW-1:0] LINE_WIDTH_RST = LwW'(640);
  localparam logic [4:0]     MIN_ARC_RST    = 5'd12;
  localparam logic [LwW-1:0] LINE_WIDTH_MIN = LwW'(2 * Radius + 1);
  localparam logic [LwW-1:0] LINE_WIDTH_MAX = LwW'(MaxWidth);
  localparam logic [4:0]     MIN_ARC_MIN    = 5'd9;
  localparam logic [4:0]     MIN_ARC_MAX    = 5'd16;

  // floor(s / 3) for s <= 765 as (s * 683) >> 11
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  // ring positions as window row / column, clockwise from the top
  localparam logic [2:0] RING_ROW [RingLen] =
    '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
      3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
  localparam logic [2:0] RING_COL [RingLen] =
    '{3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
      3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2};

  typedef logic [RingLen-1:0] ring_t;
  typedef logic [7:0] pix_t;

  // centre position info travelling with each transaction
  typedef struct packed {
    logic            valid;
    logic [ColW-1:0] cc;
    logic [RowW-1:0] cr;
  } meta_t;

endpackage

`default_nettype wire

@@ hdl/fast_corner_segment_test_unit.sv @@
// A result passes through registered stages 0 to 4 after its pixel transaction is accepted.
// Throughput: one pixel per cycle; output register and per-stage valid bits
// let the input keep flowing while a result waits until all five stages hold
// data, then stalls back up in order.
// The line store is one 6-pixel-wide word per column, read at accept and
// rewritten as it moves into stage 1. Reset clears counters, valid bits and config
// registers; line store and window contents are not cleared.
`default_nettype none

module fast_corner_segment_test_unit
  import fcst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_data_i,
  // pixel input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  blue_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  red_i,
  input  wire logic        start_of_frame_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             corner_found_o,
  output logic             centre_valid_o,
  output logic [9:0]       centre_col_o,
  output logic [11:0]      centre_row_o,
  output logic [4:0]       dark_run_length_o,
  output logic [4:0]       bright_run_length_o
);

  localparam int unsigned NStages = 5;

  // configuration registers
  logic [7:0]     threshold_q;
  logic [LwW-1:0] line_width_q;
  logic [4:0]     min_arc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RST;
      line_width_q <= LINE_WIDTH_RST;
      min_arc_q    <= MIN_ARC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:  threshold_q  <= cfg_data_i[7:0];
        CFG_LINE_WIDTH: line_width_q <= cfg_data_i[LwW-1:0];
        CFG_MIN_ARC:    min_arc_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // clamped register values
  logic [LwW-1:0] lw_eff;
  logic [4:0]     arc_eff;

  always_comb begin
    lw_eff = line_width_q;
    if (line_width_q < LINE_WIDTH_MIN) lw_eff = LINE_WIDTH_MIN;
    if (line_width_q > LINE_WIDTH_MAX) lw_eff = LINE_WIDTH_MAX;
    arc_eff = min_arc_q;
    if (min_arc_q < MIN_ARC_MIN) arc_eff = MIN_ARC_MIN;
    if (min_arc_q > MIN_ARC_MAX) arc_eff = MIN_ARC_MAX;
  end

  // pipeline flow control: stage k holds when the next one cannot take it
  logic [NStages-1:0] vld_q;
  logic [NStages:0]   rdy;
  logic [NStages-1:0] ld;

  always_comb begin
    rdy[NStages] = !out_stall_i;
    for (int k = NStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld[0] = in_valid_i && rdy[0];
    for (int k = 1; k < NStages; k++) begin
      ld[k] = vld_q[k-1] && rdy[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NStages; k++) begin
        if (ld[k]) begin
          vld_q[k] <= 1'b1;
        end else if (rdy[k+1]) begin
          vld_q[k] <= 1'b0;
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];

  // position counters, advanced per accepted transaction
  logic [ColW-1:0] col_cnt_q, col_cnt_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] cur_col;
  logic [RowW-1:0] cur_row;
  logic [LwW-1:0]  col_next;

  always_comb begin
    cur_col = col_cnt_q;
    cur_row = row_q;
    if (start_of_frame_i) begin
      cur_col = '0;
      cur_row = '0;
    end else if ({1'b0, col_cnt_q} >= lw_eff) begin
      cur_col = '0;
      if (row_q != RowW'(MaxRows - 1)) cur_row = row_q + 1'b1;
    end
    col_next  = {1'b0, cur_col} + 1'b1;
    col_cnt_d = col_next[ColW-1:0];
    row_d     = cur_row;
    if (col_next >= lw_eff) begin
      col_cnt_d = '0;
      if (cur_row != RowW'(MaxRows - 1)) row_d = cur_row + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_q     <= '0;
    end else if (ld[0]) begin
      col_cnt_q <= col_cnt_d;
      row_q     <= row_d;
    end
  end

  // grey value as the mean of the three channels
  logic [9:0]  rgb_sum;
  logic [19:0] grey_prod;
  pix_t        grey;

  always_comb begin
    rgb_sum   = 10'(blue_i) + 10'(green_i) + 10'(red_i);
    grey_prod = 20'(rgb_sum) * 20'(DIV3_MUL);
    grey      = grey_prod[DIV3_SHIFT +: 8];
  end

  // centre position and window-full flag
  meta_t cur_meta;

  always_comb begin
    cur_meta.valid = (cur_col >= ColW'(2 * Radius)) && (cur_row >= RowW'(2 * Radius));
    cur_meta.cc    = (cur_col >= ColW'(Radius)) ? cur_col - ColW'(Radius) : '0;
    cur_meta.cr    = (cur_row >= RowW'(Radius)) ? cur_row - RowW'(Radius) : '0;
  end

  // stage 0: grey, line store read, position
  pix_t            s0_grey_q;
  logic [ColW-1:0] s0_col_q;
  meta_t           s0_meta_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s0_grey_q <= grey;
      s0_col_q  <= cur_col;
      s0_meta_q <= cur_meta;
    end
  end

  // line store: one word of six stacked rows per column, line k at byte k
  logic [LineWordW-1:0] line_mem [MaxWidth];
  logic [LineWordW-1:0] line_rd_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) line_rd_q <= line_mem[cur_col];
    if (ld[1]) line_mem[s0_col_q] <= {line_rd_q[LineWordW-9:0], s0_grey_q};
  end

  // stage 1: 7x7 window shifts left, new column enters on the right
  pix_t  win_q [WinSize][WinSize];
  meta_t s1_meta_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s1_meta_q <= s0_meta_q;
      for (int r = 0; r < WinSize; r++) begin
        for (int c = 0; c < WinSize - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
      end
      win_q[WinSize-1][WinSize-1] <= s0_grey_q;
      for (int r = 0; r < WinSize - 1; r++) begin
        win_q[r][WinSize-1] <= line_rd_q[8 * (WinSize - 2 - r) +: 8];
      end
    end
  end

  // stage 2: dark and bright ring masks
  ring_t dark_mask, bright_mask;
  ring_t s2_dark_q, s2_bright_q;
  meta_t s2_meta_q;

  always_comb begin
    logic [8:0] ctr;
    logic [8:0] p;
    ctr = {1'b0, win_q[Radius][Radius]};
    dark_mask   = '0;
    bright_mask = '0;
    for (int k = 0; k < RingLen; k++) begin
      p = {1'b0, win_q[RING_ROW[k]][RING_COL[k]]};
      dark_mask[k]   = s1_meta_q.valid && ((p + {1'b0, threshold_q}) < ctr);
      bright_mask[k] = s1_meta_q.valid && (p > (ctr + {1'b0, threshold_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      s2_dark_q   <= dark_mask;
      s2_bright_q <= bright_mask;
      s2_meta_q   <= s1_meta_q;
    end
  end

  // stage 3: run prefixes, bit i of pre[j] set when the j+1 ring bits from i are all set
  ring_t dark_pre [8];
  ring_t bright_pre [8];
  ring_t s3_dark_pre_q [8];
  ring_t s3_bright_pre_q [8];
  meta_t s3_meta_q;

  always_comb begin
    logic [2*RingLen-1:0] dd, bb;
    dd = {s2_dark_q, s2_dark_q};
    bb = {s2_bright_q, s2_bright_q};
    dark_pre[0]   = s2_dark_q;
    bright_pre[0] = s2_bright_q;
    for (int j = 1; j < 8; j++) begin
      dark_pre[j]   = dark_pre[j-1] & dd[j +: RingLen];
      bright_pre[j] = bright_pre[j-1] & bb[j +: RingLen];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      s3_dark_pre_q   <= dark_pre;
      s3_bright_pre_q <= bright_pre;
      s3_meta_q       <= s2_meta_q;
    end
  end

  // stage 4: extend to 16, count run lengths, decide corner
  logic [RingLen-1:0] dark_hit, bright_hit;
  logic [4:0]         dark_len, bright_len;

  always_comb begin
    ring_t dk, bk;
    for (int j = 0; j < 8; j++) begin
      dk = s3_dark_pre_q[7] &
           {s3_dark_pre_q[j][7:0], s3_dark_pre_q[j][15:8]};
      bk = s3_bright_pre_q[7] &
           {s3_bright_pre_q[j][7:0], s3_bright_pre_q[j][15:8]};
      dark_hit[j]     = |s3_dark_pre_q[j];
      bright_hit[j]   = |s3_bright_pre_q[j];
      dark_hit[j+8]   = |dk;
      bright_hit[j+8] = |bk;
    end
    dark_len   = 5'($countones(dark_hit));
    bright_len = 5'($countones(bright_hit));
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      corner_found_o      <= (dark_len >= arc_eff) || (bright_len >= arc_eff);
      centre_valid_o      <= s3_meta_q.valid;
      centre_col_o        <= s3_meta_q.cc;
      centre_row_o        <= s3_meta_q.cr;
      dark_run_length_o   <= dark_len;
      bright_run_length_o <= bright_len;
    end
  end

  assign out_valid_o = vld_q[NStages-1];

endmodule

`default_nettype wire

@@ hdl/fcst_chk.sv @@
// port-level checker for the segment-test corner detector and its bind
`default_nettype none

module fcst_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        corner_found_o,
  input wire logic        centre_valid_o,
  input wire logic [9:0]  centre_col_o,
  input wire logic [11:0] centre_row_o,
  input wire logic [4:0]  dark_run_length_o,
  input wire logic [4:0]  bright_run_length_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(corner_found_o)
      && $stable(dark_run_length_o) && $stable(bright_run_length_o)
      && $stable(centre_col_o) && $stable(centre_row_o))
    else $error("stalled result changed");

  // invalid centre gives an empty test
  a_invalid_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !centre_valid_o |-> !corner_found_o
      && dark_run_length_o == 5'd0 && bright_run_length_o == 5'd0)
    else $error("invalid centre with nonzero test result");

  // a ring pixel cannot be both dark and bright
  a_runs_fit_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (6'(dark_run_length_o) + 6'(bright_run_length_o)) <= 6'd16)
    else $error("dark and bright runs overlap");

  // a corner needs at least the shortest allowed arc
  a_corner_arc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && corner_found_o |-> dark_run_length_o >= 5'd9
      || bright_run_length_o >= 5'd9)
    else $error("corner without a long enough run");

  // valid centre sits at least three pixels in
  a_centre_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && centre_valid_o |-> centre_col_o >= 10'd3 && centre_row_o >= 12'd3)
    else $error("valid centre too close to the edge");

endmodule

bind fast_corner_segment_test_unit fcst_chk u_fcst_chk (.*);

`default_nettype wire
